/* rtl/core/array_linked_list_with_block_locality_assert.svh */
// Assertion macros for the linked-list node store.
`ifndef ARRAY_LINKED_LIST_WITH_BLOCK_LOCALITY_ASSERT_SVH
`define ARRAY_LINKED_LIST_WITH_BLOCK_LOCALITY_ASSERT_SVH
`ifndef SYNTHESIS
`define ALB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ALB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ALB_ASSERT_SAME(label, ante, cons)
`define ALB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/alb_pkg.sv */
`default_nettype none
package alb_pkg;
  localparam int NODE_W = 8;
  localparam int NODES = 256;
  localparam int VAL_W = 32;
  localparam int STEP_W = 9;
  localparam int CNT_W = 9;
  localparam int BLOCK = 8;
  localparam int BLK_W = 3;
  localparam int BLOCK_START = 2;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam node_t FREE_SENT = NODE_W'(0);
  localparam node_t LIST_SENT = NODE_W'(1);
  localparam val_t SENT_VALUE = 32'hBEBEBEBE;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_MOVE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_TAKE_FREE, S_UNLINK_FREE, S_LINK_PREV, S_LINK_NEW,
    S_WALK_CHK, S_WALK_RD, S_BLK_CHK, S_MARK_CHK, S_MARK_RD, S_SELECT,
    S_XREAD_A, S_XREAD_B, S_XWRITE, S_RM_READ, S_RM_UNLINK, S_RM_PARK, S_RM_FREE,
    S_MOVE_CHK, S_MOVE_RD, S_FIN_RD, S_FIN_CAP, S_FIN_LIST, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    A_NONE, A_CLEAR, A_LOAD, A_DECODE, A_TAKE_FREE, A_UNLINK_FREE, A_LINK_PREV,
    A_LINK_NEW, A_WALK_CHK, A_WALK_RD, A_BLK_CHK, A_MARK_CHK, A_MARK_RD, A_SELECT,
    A_XREAD_A, A_XREAD_B, A_XWRITE, A_RM_READ, A_RM_UNLINK, A_RM_PARK, A_RM_FREE,
    A_MOVE_CHK, A_MOVE_RD, A_FIN_RD, A_FIN_CAP, A_FIN_LIST
  } act_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic legal;
    logic full;
    logic walk_done;
    logic blk_ok;
    logic mark_go;
    logic has_slot;
    logic x_last;
    logic mv_done;
    logic clr_done;
  } sts_t;

  function automatic node_t init_next(node_t i);
    node_t r;
    if (i == FREE_SENT) begin
      r = node_t'(BLOCK_START);
    end else if (i == LIST_SENT) begin
      r = LIST_SENT;
    end else begin
      r = i + node_t'(1);
    end
    return r;
  endfunction

  function automatic node_t init_prev(node_t i);
    node_t r;
    if (i == FREE_SENT) begin
      r = node_t'(NODES - 1);
    end else if (i == LIST_SENT) begin
      r = LIST_SENT;
    end else if (i == node_t'(BLOCK_START)) begin
      r = FREE_SENT;
    end else begin
      r = i - node_t'(1);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/alb_ram.sv */
`default_nettype none
module alb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end
endmodule
`default_nettype wire

/* rtl/core/alb_ctrl.sv */
`default_nettype none
module alb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  input  wire alb_pkg::sts_t sts,
  output alb_pkg::cmd_t      cmd,
  output logic               in_stall,
  output logic               out_valid
);
  alb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= alb_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alb_pkg::S_CLEAR:       if (sts.clr_done) state_nxt = alb_pkg::S_IDLE;
      alb_pkg::S_IDLE:        if (in_valid) state_nxt = alb_pkg::S_DECODE;
      alb_pkg::S_DECODE: begin
        if (!sts.legal) begin
          state_nxt = alb_pkg::S_FIN_RD;
        end else begin
          unique case (sts.op)
            alb_pkg::OP_INSERT: state_nxt = alb_pkg::S_TAKE_FREE;
            alb_pkg::OP_REMOVE: state_nxt = alb_pkg::S_RM_READ;
            alb_pkg::OP_READ:   state_nxt = alb_pkg::S_FIN_RD;
            alb_pkg::OP_MOVE:   state_nxt = alb_pkg::S_MOVE_CHK;
            default:            state_nxt = alb_pkg::S_FIN_RD;
          endcase
        end
      end
      alb_pkg::S_TAKE_FREE:
        state_nxt = sts.full ? alb_pkg::S_FIN_RD : alb_pkg::S_UNLINK_FREE;
      alb_pkg::S_UNLINK_FREE: state_nxt = alb_pkg::S_LINK_PREV;
      alb_pkg::S_LINK_PREV:   state_nxt = alb_pkg::S_LINK_NEW;
      alb_pkg::S_LINK_NEW:    state_nxt = alb_pkg::S_WALK_CHK;
      alb_pkg::S_WALK_CHK:
        state_nxt = sts.walk_done ? alb_pkg::S_BLK_CHK : alb_pkg::S_WALK_RD;
      alb_pkg::S_WALK_RD:     state_nxt = alb_pkg::S_WALK_CHK;
      alb_pkg::S_BLK_CHK:
        state_nxt = sts.blk_ok ? alb_pkg::S_MARK_CHK : alb_pkg::S_FIN_RD;
      alb_pkg::S_MARK_CHK:
        state_nxt = sts.mark_go ? alb_pkg::S_MARK_RD : alb_pkg::S_SELECT;
      alb_pkg::S_MARK_RD:     state_nxt = alb_pkg::S_MARK_CHK;
      alb_pkg::S_SELECT:
        state_nxt = sts.has_slot ? alb_pkg::S_XREAD_A : alb_pkg::S_FIN_RD;
      alb_pkg::S_XREAD_A:     state_nxt = alb_pkg::S_XREAD_B;
      alb_pkg::S_XREAD_B:     state_nxt = alb_pkg::S_XWRITE;
      alb_pkg::S_XWRITE:      if (sts.x_last) state_nxt = alb_pkg::S_FIN_RD;
      alb_pkg::S_RM_READ:     state_nxt = alb_pkg::S_RM_UNLINK;
      alb_pkg::S_RM_UNLINK:   state_nxt = alb_pkg::S_RM_PARK;
      alb_pkg::S_RM_PARK:     state_nxt = alb_pkg::S_RM_FREE;
      alb_pkg::S_RM_FREE:     state_nxt = alb_pkg::S_FIN_RD;
      alb_pkg::S_MOVE_CHK:
        state_nxt = sts.mv_done ? alb_pkg::S_FIN_RD : alb_pkg::S_MOVE_RD;
      alb_pkg::S_MOVE_RD:     state_nxt = alb_pkg::S_MOVE_CHK;
      alb_pkg::S_FIN_RD:      state_nxt = alb_pkg::S_FIN_CAP;
      alb_pkg::S_FIN_CAP:     state_nxt = alb_pkg::S_FIN_LIST;
      alb_pkg::S_FIN_LIST:    state_nxt = alb_pkg::S_OUT;
      alb_pkg::S_OUT:         if (!out_stall) state_nxt = alb_pkg::S_IDLE;
      default:                state_nxt = alb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.act   = alb_pkg::A_NONE;
    in_stall  = (state_r != alb_pkg::S_IDLE);
    out_valid = (state_r == alb_pkg::S_OUT);
    unique case (state_r)
      alb_pkg::S_CLEAR:       cmd.act = alb_pkg::A_CLEAR;
      alb_pkg::S_IDLE:        cmd.act = in_valid ? alb_pkg::A_LOAD : alb_pkg::A_NONE;
      alb_pkg::S_DECODE:      cmd.act = alb_pkg::A_DECODE;
      alb_pkg::S_TAKE_FREE:   cmd.act = alb_pkg::A_TAKE_FREE;
      alb_pkg::S_UNLINK_FREE: cmd.act = alb_pkg::A_UNLINK_FREE;
      alb_pkg::S_LINK_PREV:   cmd.act = alb_pkg::A_LINK_PREV;
      alb_pkg::S_LINK_NEW:    cmd.act = alb_pkg::A_LINK_NEW;
      alb_pkg::S_WALK_CHK:    cmd.act = alb_pkg::A_WALK_CHK;
      alb_pkg::S_WALK_RD:     cmd.act = alb_pkg::A_WALK_RD;
      alb_pkg::S_BLK_CHK:     cmd.act = alb_pkg::A_BLK_CHK;
      alb_pkg::S_MARK_CHK:    cmd.act = alb_pkg::A_MARK_CHK;
      alb_pkg::S_MARK_RD:     cmd.act = alb_pkg::A_MARK_RD;
      alb_pkg::S_SELECT:      cmd.act = alb_pkg::A_SELECT;
      alb_pkg::S_XREAD_A:     cmd.act = alb_pkg::A_XREAD_A;
      alb_pkg::S_XREAD_B:     cmd.act = alb_pkg::A_XREAD_B;
      alb_pkg::S_XWRITE:      cmd.act = alb_pkg::A_XWRITE;
      alb_pkg::S_RM_READ:     cmd.act = alb_pkg::A_RM_READ;
      alb_pkg::S_RM_UNLINK:   cmd.act = alb_pkg::A_RM_UNLINK;
      alb_pkg::S_RM_PARK:     cmd.act = alb_pkg::A_RM_PARK;
      alb_pkg::S_RM_FREE:     cmd.act = alb_pkg::A_RM_FREE;
      alb_pkg::S_MOVE_CHK:    cmd.act = alb_pkg::A_MOVE_CHK;
      alb_pkg::S_MOVE_RD:     cmd.act = alb_pkg::A_MOVE_RD;
      alb_pkg::S_FIN_RD:      cmd.act = alb_pkg::A_FIN_RD;
      alb_pkg::S_FIN_CAP:     cmd.act = alb_pkg::A_FIN_CAP;
      alb_pkg::S_FIN_LIST:    cmd.act = alb_pkg::A_FIN_LIST;
      alb_pkg::S_OUT:         cmd.act = alb_pkg::A_NONE;
      default:                cmd.act = alb_pkg::A_NONE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/alb_dp.sv */
`default_nettype none
module alb_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire alb_pkg::cmd_t                cmd,
  output alb_pkg::sts_t                     sts,
  input  wire logic [1:0]                   in_operation,
  input  wire logic [alb_pkg::NODE_W-1:0]   in_node,
  input  wire logic [alb_pkg::VAL_W-1:0]    in_value,
  input  wire logic [alb_pkg::STEP_W-1:0]   in_steps,
  output logic [1:0]                        out_status,
  output logic [alb_pkg::NODE_W-1:0]        out_result_node,
  output logic [alb_pkg::VAL_W-1:0]         out_result_value,
  output logic [alb_pkg::NODE_W-1:0]        out_prev_node,
  output logic [alb_pkg::NODE_W-1:0]        out_next_node,
  output logic [alb_pkg::NODE_W-1:0]        out_head_node,
  output logic [alb_pkg::NODE_W-1:0]        out_tail_node,
  output logic [alb_pkg::NODE_W-1:0]        out_count
);
  localparam int NW = alb_pkg::NODE_W;

  alb_pkg::node_t rd_addr, rd_nx, rd_pv;
  alb_pkg::val_t  rd_vl;
  logic           nx_we, pv_we, vl_we;
  alb_pkg::node_t nx_wa, nx_wd, pv_wa, pv_wd, vl_wa;
  alb_pkg::val_t  vl_wd;
  logic           lv_we, lv_wd, rd_lv;
  alb_pkg::node_t lv_wa, lv_ra;

  alb_pkg::op_t   op_r, op_nxt;
  alb_pkg::node_t node_r, node_nxt, fresh_r, fresh_nxt, before_r, before_nxt;
  alb_pkg::node_t p_r, p_nxt, res_r, res_nxt;
  alb_pkg::node_t a_r, a_nxt, b_r, b_nxt, pa_r, pa_nxt, na_r, na_nxt;
  alb_pkg::node_t pb_r, pb_nxt, nb_r, nb_nxt, clr_r, clr_nxt, count_r, count_nxt;
  alb_pkg::val_t  val_r, val_nxt, va_r, va_nxt, vb_r, vb_nxt;
  logic [alb_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [alb_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [alb_pkg::BLOCK-1:0]  mark_r, mark_nxt;
  logic [1:0]     xstep_r, xstep_nxt;
  logic           neg_r, neg_nxt, ok_r, ok_nxt, la_r, la_nxt;
  alb_pkg::status_t status_r, status_nxt;
  logic [1:0]     o_status_r, o_status_nxt;
  alb_pkg::node_t o_res_r, o_res_nxt, o_prev_r, o_prev_nxt, o_next_r, o_next_nxt;
  alb_pkg::node_t o_head_r, o_head_nxt, o_tail_r, o_tail_nxt, o_count_r, o_count_nxt;
  alb_pkg::val_t  o_val_r, o_val_nxt;

  logic [NW:0]    blk_end;
  logic [alb_pkg::BLK_W-1:0] slot_k, mark_idx;
  alb_pkg::node_t slot;
  logic           adj, legal;

  assign lv_ra = (cmd.act == alb_pkg::A_LOAD) ? in_node : rd_addr;

  alb_ram #(.WIDTH(NW), .DEPTH(alb_pkg::NODES)) u_next_ram (
    .clk(clk), .we(nx_we), .wa(nx_wa), .wd(nx_wd), .ra(rd_addr), .rd(rd_nx)
  );
  alb_ram #(.WIDTH(NW), .DEPTH(alb_pkg::NODES)) u_prev_ram (
    .clk(clk), .we(pv_we), .wa(pv_wa), .wd(pv_wd), .ra(rd_addr), .rd(rd_pv)
  );
  alb_ram #(.WIDTH(alb_pkg::VAL_W), .DEPTH(alb_pkg::NODES)) u_value_ram (
    .clk(clk), .we(vl_we), .wa(vl_wa), .wd(vl_wd), .ra(rd_addr), .rd(rd_vl)
  );
  alb_ram #(.WIDTH(1), .DEPTH(alb_pkg::NODES)) u_live_ram (
    .clk(clk), .we(lv_we), .wa(lv_wa), .wd(lv_wd), .ra(lv_ra), .rd(rd_lv)
  );

  always_comb begin
    blk_end  = {1'b0, before_r} + (NW+1)'(alb_pkg::BLOCK);
    mark_idx = alb_pkg::BLK_W'(p_r - before_r);
    slot_k   = '0;
    for (int k = alb_pkg::BLOCK - 1; k >= 0; k--) begin
      if (!mark_r[k]) slot_k = alb_pkg::BLK_W'(k);
    end
    slot  = before_r + NW'(slot_k);
    adj   = (na_r == b_r);
    legal = ((node_r == alb_pkg::LIST_SENT) || rd_lv) &&
            !((op_r == alb_pkg::OP_REMOVE) && (node_r == alb_pkg::LIST_SENT));
    sts.op        = op_r;
    sts.legal     = legal;
    sts.full      = (rd_nx == alb_pkg::FREE_SENT);
    sts.walk_done = (before_r[alb_pkg::BLK_W-1:0] == alb_pkg::BLK_W'(alb_pkg::BLOCK_START)) ||
                    (cnt_r == alb_pkg::CNT_W'(alb_pkg::BLOCK));
    sts.blk_ok    = (before_r[alb_pkg::BLK_W-1:0] == alb_pkg::BLK_W'(alb_pkg::BLOCK_START)) &&
                    (blk_end <= (NW+1)'(alb_pkg::NODES)) &&
                    !((fresh_r >= before_r) && ({1'b0, fresh_r} < blk_end));
    sts.mark_go   = (cnt_r < alb_pkg::CNT_W'(alb_pkg::BLOCK)) && (p_r >= before_r) &&
                    ({1'b0, p_r} < blk_end);
    sts.has_slot  = !(&mark_r);
    sts.x_last    = adj ? (xstep_r == 2'd2) : (xstep_r == 2'd3);
    sts.mv_done   = (cnt_r == '0);
    sts.clr_done  = (clr_r == alb_pkg::node_t'(alb_pkg::NODES - 1));
  end

  always_comb begin
    op_nxt = op_r; node_nxt = node_r; val_nxt = val_r; steps_nxt = steps_r;
    fresh_nxt = fresh_r; before_nxt = before_r; p_nxt = p_r; res_nxt = res_r;
    a_nxt = a_r; b_nxt = b_r; pa_nxt = pa_r; na_nxt = na_r; pb_nxt = pb_r; nb_nxt = nb_r;
    va_nxt = va_r; vb_nxt = vb_r; cnt_nxt = cnt_r; mark_nxt = mark_r; la_nxt = la_r;
    xstep_nxt = xstep_r; neg_nxt = neg_r; ok_nxt = ok_r; status_nxt = status_r;
    clr_nxt = clr_r; count_nxt = count_r;
    o_status_nxt = o_status_r; o_res_nxt = o_res_r; o_val_nxt = o_val_r;
    o_prev_nxt = o_prev_r; o_next_nxt = o_next_r; o_head_nxt = o_head_r;
    o_tail_nxt = o_tail_r; o_count_nxt = o_count_r;
    rd_addr = alb_pkg::FREE_SENT;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    vl_we = 1'b0; vl_wa = '0; vl_wd = '0;
    lv_we = 1'b0; lv_wa = '0; lv_wd = 1'b0;
    unique case (cmd.act)
      alb_pkg::A_NONE: begin
      end
      alb_pkg::A_CLEAR: begin
        nx_we = 1'b1; nx_wa = clr_r; nx_wd = alb_pkg::init_next(clr_r);
        pv_we = 1'b1; pv_wa = clr_r; pv_wd = alb_pkg::init_prev(clr_r);
        lv_we = 1'b1; lv_wa = clr_r; lv_wd = 1'b0;
        clr_nxt = clr_r + NW'(1);
      end
      alb_pkg::A_LOAD: begin
        op_nxt    = alb_pkg::op_t'(in_operation);
        node_nxt  = in_node;
        val_nxt   = in_value;
        steps_nxt = in_steps;
      end
      alb_pkg::A_DECODE: begin
        rd_addr    = (op_r == alb_pkg::OP_INSERT) ? alb_pkg::FREE_SENT : node_r;
        res_nxt    = node_r;
        ok_nxt     = legal;
        status_nxt = legal ? alb_pkg::ST_OK : alb_pkg::ST_ILLEGAL;
        neg_nxt    = steps_r[alb_pkg::STEP_W-1];
        cnt_nxt    = steps_r[alb_pkg::STEP_W-1] ? (alb_pkg::CNT_W'(0) - steps_r) : steps_r;
      end
      alb_pkg::A_TAKE_FREE: begin
        fresh_nxt = rd_nx;
        rd_addr   = rd_nx;
        if (rd_nx == alb_pkg::FREE_SENT) begin
          status_nxt = alb_pkg::ST_FULL;
          ok_nxt     = 1'b0;
        end
      end
      alb_pkg::A_UNLINK_FREE: begin
        pv_we = 1'b1; pv_wa = rd_nx; pv_wd = alb_pkg::FREE_SENT;
        nx_we = 1'b1; nx_wa = alb_pkg::FREE_SENT; nx_wd = rd_nx;
        rd_addr = node_r;
      end
      alb_pkg::A_LINK_PREV: begin
        before_nxt = rd_pv;
        nx_we = 1'b1; nx_wa = rd_pv; nx_wd = fresh_r;
        pv_we = 1'b1; pv_wa = node_r; pv_wd = fresh_r;
      end
      alb_pkg::A_LINK_NEW: begin
        nx_we = 1'b1; nx_wa = fresh_r; nx_wd = node_r;
        pv_we = 1'b1; pv_wa = fresh_r; pv_wd = before_r;
        vl_we = 1'b1; vl_wa = fresh_r; vl_wd = val_r;
        lv_we = 1'b1; lv_wa = fresh_r; lv_wd = 1'b1;
        count_nxt = count_r + NW'(1);
        cnt_nxt   = '0;
        res_nxt   = fresh_r;
      end
      alb_pkg::A_WALK_CHK: begin
        rd_addr = before_r;
        if (!sts.walk_done) cnt_nxt = cnt_r + alb_pkg::CNT_W'(1);
      end
      alb_pkg::A_WALK_RD: before_nxt = rd_pv;
      alb_pkg::A_BLK_CHK: begin
        p_nxt    = before_r;
        cnt_nxt  = '0;
        mark_nxt = '0;
      end
      alb_pkg::A_MARK_CHK: begin
        rd_addr = p_r;
        if (sts.mark_go) begin
          mark_nxt[mark_idx] = 1'b1;
          cnt_nxt = cnt_r + alb_pkg::CNT_W'(1);
        end
      end
      alb_pkg::A_MARK_RD: p_nxt = rd_nx;
      alb_pkg::A_SELECT: begin
        rd_addr = slot;
        a_nxt   = slot;
        b_nxt   = fresh_r;
        if (sts.has_slot) res_nxt = slot;
      end
      alb_pkg::A_XREAD_A: begin
        pa_nxt = rd_pv; na_nxt = rd_nx; va_nxt = rd_vl;
        la_nxt = rd_lv;
        rd_addr = b_r;
      end
      alb_pkg::A_XREAD_B: begin
        xstep_nxt = '0;
        if (rd_nx == a_r) begin
          a_nxt = b_r; b_nxt = a_r;
          pa_nxt = rd_pv; na_nxt = rd_nx; va_nxt = rd_vl;
          pb_nxt = pa_r; nb_nxt = na_r; vb_nxt = va_r;
        end else begin
          pb_nxt = rd_pv; nb_nxt = rd_nx; vb_nxt = rd_vl;
        end
      end
      alb_pkg::A_XWRITE: begin
        xstep_nxt = xstep_r + 2'd1;
        nx_we = 1'b1; pv_we = 1'b1;
        if (adj) begin
          unique case (xstep_r)
            2'd0: begin nx_wa = pa_r; nx_wd = b_r; pv_wa = b_r;  pv_wd = pa_r; end
            2'd1: begin nx_wa = b_r;  nx_wd = a_r; pv_wa = a_r;  pv_wd = b_r;  end
            default: begin nx_wa = a_r; nx_wd = nb_r; pv_wa = nb_r; pv_wd = a_r; end
          endcase
        end else begin
          unique case (xstep_r)
            2'd0: begin nx_wa = a_r;  nx_wd = nb_r; pv_wa = a_r;  pv_wd = pb_r; end
            2'd1: begin nx_wa = b_r;  nx_wd = na_r; pv_wa = b_r;  pv_wd = pa_r; end
            2'd2: begin nx_wa = pa_r; nx_wd = b_r;  pv_wa = na_r; pv_wd = b_r;  end
            default: begin nx_wa = pb_r; nx_wd = a_r; pv_wa = nb_r; pv_wd = a_r; end
          endcase
        end
        if (xstep_r == 2'd0) begin
          vl_we = 1'b1; vl_wa = a_r; vl_wd = vb_r;
          lv_we = 1'b1; lv_wa = res_r; lv_wd = 1'b1;
        end else if (xstep_r == 2'd1) begin
          vl_we = 1'b1; vl_wa = b_r; vl_wd = va_r;
          lv_we = 1'b1; lv_wa = fresh_r; lv_wd = la_r;
        end
      end
      alb_pkg::A_RM_READ: begin
        p_nxt      = rd_nx;
        before_nxt = rd_pv;
        rd_addr    = alb_pkg::FREE_SENT;
      end
      alb_pkg::A_RM_UNLINK: begin
        a_nxt = rd_pv;
        nx_we = 1'b1; nx_wa = before_r; nx_wd = p_r;
        pv_we = 1'b1; pv_wa = p_r; pv_wd = before_r;
      end
      alb_pkg::A_RM_PARK: begin
        pv_we = 1'b1; pv_wa = node_r; pv_wd = a_r;
        nx_we = 1'b1; nx_wa = node_r; nx_wd = alb_pkg::FREE_SENT;
      end
      alb_pkg::A_RM_FREE: begin
        nx_we = 1'b1; nx_wa = a_r; nx_wd = node_r;
        pv_we = 1'b1; pv_wa = alb_pkg::FREE_SENT; pv_wd = node_r;
        lv_we = 1'b1; lv_wa = node_r; lv_wd = 1'b0;
        count_nxt = count_r - NW'(1);
        res_nxt   = p_r;
      end
      alb_pkg::A_MOVE_CHK: begin
        rd_addr = res_r;
        if (!sts.mv_done) cnt_nxt = cnt_r - alb_pkg::CNT_W'(1);
      end
      alb_pkg::A_MOVE_RD: res_nxt = neg_r ? rd_pv : rd_nx;
      alb_pkg::A_FIN_RD: rd_addr = res_r;
      alb_pkg::A_FIN_CAP: begin
        rd_addr      = alb_pkg::LIST_SENT;
        o_status_nxt = status_r;
        if (ok_r) begin
          o_res_nxt  = res_r;
          o_prev_nxt = rd_pv;
          o_next_nxt = rd_nx;
          o_val_nxt  = ((res_r == alb_pkg::FREE_SENT) || (res_r == alb_pkg::LIST_SENT)) ?
                       alb_pkg::SENT_VALUE : rd_vl;
        end else begin
          o_res_nxt = '0; o_prev_nxt = '0; o_next_nxt = '0; o_val_nxt = '0;
        end
      end
      alb_pkg::A_FIN_LIST: begin
        o_head_nxt  = rd_nx;
        o_tail_nxt  = rd_pv;
        o_count_nxt = count_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      count_r <= '0;
    end else begin
      clr_r   <= clr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; node_r <= node_nxt; val_r <= val_nxt; steps_r <= steps_nxt;
    fresh_r <= fresh_nxt; before_r <= before_nxt; p_r <= p_nxt; res_r <= res_nxt;
    a_r <= a_nxt; b_r <= b_nxt; pa_r <= pa_nxt; na_r <= na_nxt; pb_r <= pb_nxt;
    nb_r <= nb_nxt; va_r <= va_nxt; vb_r <= vb_nxt; cnt_r <= cnt_nxt; mark_r <= mark_nxt;
    xstep_r <= xstep_nxt; neg_r <= neg_nxt; ok_r <= ok_nxt; status_r <= status_nxt;
    la_r <= la_nxt;
    o_status_r <= o_status_nxt; o_res_r <= o_res_nxt; o_val_r <= o_val_nxt;
    o_prev_r <= o_prev_nxt; o_next_r <= o_next_nxt; o_head_r <= o_head_nxt;
    o_tail_r <= o_tail_nxt; o_count_r <= o_count_nxt;
  end

  assign out_status       = o_status_r;
  assign out_result_node  = o_res_r;
  assign out_result_value = o_val_r;
  assign out_prev_node    = o_prev_r;
  assign out_next_node    = o_next_r;
  assign out_head_node    = o_head_r;
  assign out_tail_node    = o_tail_r;
  assign out_count        = o_count_r;
endmodule
`default_nettype wire

/* rtl/core/array_linked_list_with_block_locality.sv */
// Node store of 256 entries holding an item list (sentinel node 1) and a free
// ring (sentinel node 0) as doubly linked rings; operations insert-before,
// remove, read and signed move. After reset a pass initializes the link and
// liveness memories, during which no item is taken. One item is in flight at
// a time, and its cost follows the links touched: an illegal node or an insert
// into a full store ends early, and an insert adds the block walk, marking and
// node exchange; the result then waits on out_stall before it is taken.
`default_nettype none
`include "array_linked_list_with_block_locality_assert.svh"
module array_linked_list_with_block_locality (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_operation,
  input  wire logic [alb_pkg::NODE_W-1:0]        in_node,
  input  wire logic signed [alb_pkg::VAL_W-1:0]  in_value,
  input  wire logic signed [alb_pkg::STEP_W-1:0] in_steps,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_status,
  output logic [alb_pkg::NODE_W-1:0]             out_result_node,
  output logic signed [alb_pkg::VAL_W-1:0]       out_result_value,
  output logic [alb_pkg::NODE_W-1:0]             out_prev_node,
  output logic [alb_pkg::NODE_W-1:0]             out_next_node,
  output logic [alb_pkg::NODE_W-1:0]             out_head_node,
  output logic [alb_pkg::NODE_W-1:0]             out_tail_node,
  output logic [alb_pkg::NODE_W-1:0]             out_count
);
  alb_pkg::cmd_t cmd;
  alb_pkg::sts_t sts;
  logic [alb_pkg::VAL_W-1:0] res_value;

  alb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd), .in_stall(in_stall), .out_valid(out_valid)
  );

  alb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_node(in_node),
    .in_value($unsigned(in_value)), .in_steps($unsigned(in_steps)),
    .out_status(out_status), .out_result_node(out_result_node),
    .out_result_value(res_value), .out_prev_node(out_prev_node),
    .out_next_node(out_next_node), .out_head_node(out_head_node),
    .out_tail_node(out_tail_node), .out_count(out_count)
  );

  assign out_result_value = $signed(res_value);

  `ALB_ASSERT_SAME(a_busy_while_result, out_valid, in_stall)
  `ALB_ASSERT_NEXT(a_single_result, out_valid && !out_stall, !out_valid)
  `ALB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ALB_ASSERT_SAME(a_status_code, out_valid, (out_status == alb_pkg::ST_OK) || (out_status == alb_pkg::ST_FULL) || (out_status == alb_pkg::ST_ILLEGAL))
endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  rnode;
    logic [31:0] rvalue;
    logic [7:0]  prv;
    logic [7:0]  nxt;
    logic [7:0]  head;
    logic [7:0]  tail;
    logic [7:0]  cnt;
  } answer_t;

  class list_scoreboard;
    logic [31:0] vals[256];
    logic [7:0]  nx[256];
    logic [7:0]  pv[256];
    bit          live[256];
    int          items;
    answer_t     pending[$];
    int          errors;

    function new();
      for (int i = 0; i < 256; i++) begin
        vals[i] = 0;
        live[i] = 0;
        nx[i] = (i == 255) ? 8'd0 : 8'(i + 1);
        pv[i] = (i == 2) ? 8'd0 : 8'(i - 1);
      end
      nx[0] = 8'd2;
      pv[0] = 8'd255;
      nx[1] = 8'd1;
      pv[1] = 8'd1;
      vals[0] = alb_pkg::SENT_VALUE;
      vals[1] = alb_pkg::SENT_VALUE;
      items = 0;
      errors = 0;
    endfunction

    function void swap_nodes(int a, int b);
      int pa, na, pb, nb, t;
      bit lt;
      if (a == b) return;
      if (nx[b] == a) begin
        t = a; a = b; b = t;
      end
      pa = pv[a]; na = nx[a]; pb = pv[b]; nb = nx[b];
      if (na == b) begin
        nx[pa] = b; nx[b] = a; nx[a] = nb;
        pv[b] = pa; pv[a] = b; pv[nb] = a;
      end else begin
        nx[a] = nb; pv[a] = pb; nx[b] = na; pv[b] = pa;
        nx[pa] = b; pv[na] = b; nx[pb] = a; pv[nb] = a;
      end
      t = vals[a]; vals[a] = vals[b]; vals[b] = t;
      lt = live[a]; live[a] = live[b]; live[b] = lt;
    endfunction

    function int insert_before(int at, logic [31:0] v);
      int fresh, rest, prior, start, p;
      bit mark[8];
      fresh = nx[0];
      rest = nx[fresh];
      pv[rest] = 0;
      nx[0] = rest;
      prior = pv[at];
      nx[prior] = fresh;
      pv[at] = fresh;
      nx[fresh] = at;
      pv[fresh] = prior;
      vals[fresh] = v;
      live[fresh] = 1;
      items++;
      for (int i = 0; (prior % 8) != 2 && i < 8; i++) prior = pv[prior];
      if ((prior % 8) != 2) return fresh;
      start = prior;
      if (start + 8 > 256 || (start <= fresh && fresh < start + 8)) return fresh;
      for (int i = 0; i < 8; i++) mark[i] = 0;
      p = start;
      for (int i = 0; i < 8 && start <= p && p < start + 8; i++) begin
        mark[p - start] = 1;
        p = nx[p];
      end
      for (int i = 0; i < 8; i++) begin
        if (!mark[i]) begin
          swap_nodes(start + i, fresh);
          return start + i;
        end
      end
      return fresh;
    endfunction

    function void note_transfer(logic [1:0] op, logic [7:0] node, logic [31:0] v,
                                logic [8:0] steps);
      answer_t a;
      int res, n, prior, after, ft;
      bit ok, legal;
      ok = 0;
      res = 0;
      a.status = alb_pkg::ST_OK;
      legal = (node == alb_pkg::LIST_SENT) || live[node];
      if (op == alb_pkg::OP_REMOVE) legal = legal && node != alb_pkg::LIST_SENT;
      if (!legal) begin
        a.status = alb_pkg::ST_ILLEGAL;
      end else if (op == alb_pkg::OP_INSERT) begin
        if (nx[0] == 0) a.status = alb_pkg::ST_FULL;
        else begin
          res = insert_before(node, v);
          ok = 1;
        end
      end else if (op == alb_pkg::OP_REMOVE) begin
        after = nx[node]; prior = pv[node]; ft = pv[0];
        nx[prior] = after; pv[after] = prior;
        pv[node] = ft; nx[node] = 0; nx[ft] = node; pv[0] = node;
        live[node] = 0;
        items--;
        res = after;
        ok = 1;
      end else if (op == alb_pkg::OP_READ) begin
        res = node;
        ok = 1;
      end else begin
        res = node;
        if (steps[8]) begin
          n = 512 - steps;
          for (int i = 0; i < n; i++) res = pv[res];
        end else begin
          for (int i = 0; i < steps; i++) res = nx[res];
        end
        ok = 1;
      end
      if (ok) begin
        a.rnode = res; a.rvalue = vals[res]; a.prv = pv[res]; a.nxt = nx[res];
      end else begin
        a.rnode = 0; a.rvalue = 0; a.prv = 0; a.nxt = 0;
      end
      a.head = nx[1];
      a.tail = pv[1];
      a.cnt = 8'(items);
      pending.push_back(a);
    endfunction

    function void check_transfer(answer_t got);
      answer_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result node %0d", $time, got.rnode);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.status !== got.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status); errors++;
      end
      if (e.rnode !== got.rnode) begin
        $display("%0t: result_node exp %0d got %0d", $time, e.rnode, got.rnode); errors++;
      end
      if (e.rvalue !== got.rvalue) begin
        $display("%0t: result_value exp %h got %h", $time, e.rvalue, got.rvalue); errors++;
      end
      if (e.prv !== got.prv) begin
        $display("%0t: prev_node exp %0d got %0d", $time, e.prv, got.prv); errors++;
      end
      if (e.nxt !== got.nxt) begin
        $display("%0t: next_node exp %0d got %0d", $time, e.nxt, got.nxt); errors++;
      end
      if (e.head !== got.head) begin
        $display("%0t: head_node exp %0d got %0d", $time, e.head, got.head); errors++;
      end
      if (e.tail !== got.tail) begin
        $display("%0t: tail_node exp %0d got %0d", $time, e.tail, got.tail); errors++;
      end
      if (e.cnt !== got.cnt) begin
        $display("%0t: count exp %0d got %0d", $time, e.cnt, got.cnt); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_operation = 0;
  logic [7:0]  in_node = 0;
  logic signed [31:0] in_value = 0;
  logic signed [8:0]  in_steps = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_result_node, out_prev_node, out_next_node;
  logic [7:0]  out_head_node, out_tail_node, out_count;
  logic signed [31:0] out_result_value;

  list_scoreboard board = new();
  int  cycles = 0;
  bit  long_hold = 0;
  bit  feeding_done = 0;

  always #5 clk = ~clk;

  array_linked_list_with_block_locality i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_node(in_node),
    .in_value(in_value), .in_steps(in_steps),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_node(out_result_node),
    .out_result_value(out_result_value), .out_prev_node(out_prev_node),
    .out_next_node(out_next_node), .out_head_node(out_head_node),
    .out_tail_node(out_tail_node), .out_count(out_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && in_valid && !in_stall)
      board.note_transfer(in_operation, in_node, in_value, in_steps);
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status; got.rnode = out_result_node;
      got.rvalue = out_result_value; got.prv = out_prev_node;
      got.nxt = out_next_node; got.head = out_head_node;
      got.tail = out_tail_node; got.cnt = out_count;
      board.check_transfer(got);
    end
  end

  initial begin
    int mode;
    int len;
    @(posedge clk);
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 60);
      for (int i = 0; i < len; i++) begin
        @(posedge clk);
        if (long_hold) out_stall <= 1;
        else if (mode == 0) out_stall <= 0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] node, logic [31:0] v, logic [8:0] s);
    in_valid <= 1;
    in_operation <= op;
    in_node <= node;
    in_value <= v;
    in_steps <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_node();
    int k;
    int n;
    k = $urandom_range(0, 99);
    if (k < 8) return 8'($urandom_range(0, 255));
    if (k < 16) return alb_pkg::LIST_SENT;
    if (board.items == 0) return alb_pkg::LIST_SENT;
    n = $urandom_range(0, board.items - 1);
    for (int i = 2; i < 256; i++) begin
      if (board.live[i]) begin
        if (n == 0) return 8'(i);
        n--;
      end
    end
    return alb_pkg::LIST_SENT;
  endfunction

  task automatic random_item(int ins_weight);
    logic [1:0] op;
    int k;
    logic [8:0] s;
    k = $urandom_range(0, 99);
    if (k < ins_weight) op = alb_pkg::OP_INSERT;
    else if (k < ins_weight + 20) op = alb_pkg::OP_REMOVE;
    else if (k < ins_weight + 35) op = alb_pkg::OP_READ;
    else op = alb_pkg::OP_MOVE;
    if ($urandom_range(0, 9) == 0) s = 9'($urandom);
    else s = 9'($urandom_range(0, 16) - 8);
    send(op, pick_node(), $urandom, s);
  endtask

  initial begin
    int burst;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(alb_pkg::OP_READ, alb_pkg::LIST_SENT, 0, 0);
    send(alb_pkg::OP_REMOVE, alb_pkg::LIST_SENT, 0, 0);
    send(alb_pkg::OP_READ, 8'd0, 0, 0);
    send(alb_pkg::OP_READ, 8'd255, 0, 0);
    send(alb_pkg::OP_MOVE, alb_pkg::LIST_SENT, 0, 9'sd3);
    send(alb_pkg::OP_INSERT, alb_pkg::LIST_SENT, 32'h7FFFFFFF, 0);
    send(alb_pkg::OP_INSERT, alb_pkg::LIST_SENT, 32'h80000000, 0);
    send(alb_pkg::OP_INSERT, 8'd2, 32'hFFFFFFFF, 0);
    send(alb_pkg::OP_INSERT, 8'd3, 32'h0, 0);
    send(alb_pkg::OP_READ, 8'd2, 0, 0);
    send(alb_pkg::OP_MOVE, 8'd2, 0, 9'h0FF);
    send(alb_pkg::OP_MOVE, 8'd2, 0, 9'h101);
    send(alb_pkg::OP_MOVE, alb_pkg::LIST_SENT, 0, 9'h1FF);
    send(alb_pkg::OP_REMOVE, 8'd3, 0, 0);
    send(alb_pkg::OP_REMOVE, 8'd3, 0, 0);
    send(alb_pkg::OP_INSERT, 8'd0, 32'h12345678, 0);
    send(alb_pkg::OP_INSERT, 8'd200, 32'h5A5A5A5A, 0);
    pause();
    for (int i = 0; i < 300; i++) random_item(i < 150 ? 75 : 35);
    long_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      for (int i = 0; i < 6; i++) random_item(40);
    join
    while (board.items < 254) send(alb_pkg::OP_INSERT, pick_node(), $urandom, 0);
    send(alb_pkg::OP_INSERT, alb_pkg::LIST_SENT, 32'h1, 0);
    send(alb_pkg::OP_INSERT, pick_node(), 32'h2, 0);
    for (int i = 0; i < 180; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 20);
        in_valid <= 0;
        repeat (burst) @(posedge clk);
      end
      random_item(i < 90 ? 15 : 40);
    end
    in_valid <= 0;
    feeding_done = 1;
  end

  initial begin
    wait (feeding_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/alb_pkg.sv
rtl/core/alb_ram.sv
rtl/core/alb_ctrl.sv
rtl/core/alb_dp.sv
rtl/core/array_linked_list_with_block_locality.sv
test/testbench.sv
